// ===== rtl/kbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// kbsd_pkg
// Shared types and constants of the keyed byte stream deobfuscator.
// ----------------------------------------------------------------------------
package kbsd_pkg;

  localparam int HdrBytes = 17;
  localparam int PosW     = 34;

  localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2   = 64'h94D049BB133111EB;
  localparam logic [63:0] TAG_SALT   = 64'h4D495F55495F564D;
  localparam logic [63:0] TAG_BIAS   = 64'h0000000000000100;

  localparam logic [7:0] OP_XOR = 8'h31;
  localparam logic [7:0] OP_ROT = 8'h32;
  localparam logic [7:0] OP_SUB = 8'h33;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_LENGTH  = 3'd4;
  localparam logic [2:0] ST_BAD_OP  = 3'd5;
  localparam logic [2:0] ST_TAG     = 3'd6;

  typedef enum logic [1:0] {
    MIX_KS_INIT  = 2'd0,
    MIX_TAG_INIT = 2'd1,
    MIX_KS_STEP  = 2'd2,
    MIX_TAG_STEP = 2'd3
  } mix_sel_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } src_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] plain_byte;
    logic [2:0] status;
    logic       end_of_message;
  } res_t;

  typedef struct packed {
    logic       latch;
    logic       hdr_store;
    logic       pend_store;
    logic       pos_inc;
    logic       close;
    logic       swallow;
    logic       mix_start;
    mix_sel_t   mix_sel;
    logic       ks_wr;
    logic       tag_wr;
    logic       out_plain;
    logic       out_status;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic       swallow;
    logic       err;
    logic [2:0] err_code;
    logic       hdr_step;
    logic       hdr_final;
    logic       op_byte;
    logic       last;
    logic       len_zero;
    logic       final_byte;
    logic       tag_ok;
    logic       mix_done;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/kbsd_mix.sv =====
// ----------------------------------------------------------------------------
// kbsd_mix
// SplitMix64 finalizer, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module kbsd_mix (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);
  import kbsd_pkg::*;

  localparam logic [3:0] PH_XS30 = 4'd0;
  localparam logic [3:0] PH_M1A  = 4'd1;
  localparam logic [3:0] PH_M1B  = 4'd2;
  localparam logic [3:0] PH_M1C  = 4'd3;
  localparam logic [3:0] PH_XS27 = 4'd4;
  localparam logic [3:0] PH_M2A  = 4'd5;
  localparam logic [3:0] PH_M2B  = 4'd6;
  localparam logic [3:0] PH_M2C  = 4'd7;
  localparam logic [3:0] PH_XS31 = 4'd8;

  logic [3:0]  ph;
  logic [63:0] v;
  logic [63:0] acc;
  logic [63:0] cmul;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;

  assign cmul   = (ph < PH_XS27) ? MIX_MUL1 : MIX_MUL2;
  assign prod   = ma * mb;
  assign result = v;

  always_comb begin
    case (ph)
      PH_M1B, PH_M2B: begin
        ma = v[31:0];
        mb = cmul[63:32];
      end
      PH_M1C, PH_M2C: begin
        ma = v[63:32];
        mb = cmul[31:0];
      end
      default: begin
        ma = v[31:0];
        mb = cmul[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= PH_XS30;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ph   <= PH_XS30;
        v    <= arg + MIX_GOLDEN;
      end else if (busy) begin
        ph <= ph + 4'd1;
        case (ph)
          PH_XS30:        v   <= v ^ (v >> 30);
          PH_M1A, PH_M2A: acc <= prod;
          PH_M1B, PH_M1C,
          PH_M2B, PH_M2C: acc <= acc + {prod[31:0], 32'b0};
          PH_XS27:        v   <= acc ^ (acc >> 27);
          default: begin
            v    <= acc ^ (acc >> 31);
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/kbsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbsd_ctrl
// Sequencer: classifies each byte and steps the datapath through it.
// ----------------------------------------------------------------------------
module kbsd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  kbsd_pkg::stat_t st,
  output kbsd_pkg::cmd_t  cmd
);
  import kbsd_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EVAL     = 10'b0000000010,
    S_KS_INIT  = 10'b0000000100,
    S_TAG_INIT = 10'b0000001000,
    S_HDR_CHK  = 10'b0000010000,
    S_KS_STEP  = 10'b0000100000,
    S_PLAIN    = 10'b0001000000,
    S_TAG_STEP = 10'b0010000000,
    S_FIN      = 10'b0100000000,
    S_STAT     = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] code, code_next;

  assign src_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    unique case (state)
      S_IDLE: begin
        if (src_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.swallow) begin
          cmd.swallow = 1'b1;
          state_next  = S_IDLE;
        end else if (st.err) begin
          code_next  = st.err_code;
          state_next = S_STAT;
        end else if (st.hdr_step) begin
          cmd.hdr_store = 1'b1;
          cmd.pos_inc   = 1'b1;
          state_next    = S_IDLE;
        end else if (st.hdr_final) begin
          cmd.hdr_store = 1'b1;
          cmd.mix_start = 1'b1;
          cmd.mix_sel   = MIX_KS_INIT;
          state_next    = S_KS_INIT;
        end else if (st.op_byte) begin
          cmd.pend_store = 1'b1;
          cmd.pos_inc    = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.mix_start = 1'b1;
          cmd.mix_sel   = MIX_KS_STEP;
          state_next    = S_KS_STEP;
        end
      end
      S_KS_INIT: begin
        if (st.mix_done) begin
          cmd.ks_wr     = 1'b1;
          cmd.mix_start = 1'b1;
          cmd.mix_sel   = MIX_TAG_INIT;
          state_next    = S_TAG_INIT;
        end
      end
      S_TAG_INIT: begin
        if (st.mix_done) begin
          cmd.tag_wr = 1'b1;
          state_next = S_HDR_CHK;
        end
      end
      S_HDR_CHK: begin
        if (st.len_zero) begin
          code_next  = !st.last ? ST_LENGTH : (st.tag_ok ? ST_OK : ST_TAG);
          state_next = S_STAT;
        end else if (st.last) begin
          code_next  = ST_LENGTH;
          state_next = S_STAT;
        end else begin
          cmd.pos_inc = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_KS_STEP: begin
        if (st.mix_done) begin
          cmd.ks_wr  = 1'b1;
          state_next = S_PLAIN;
        end
      end
      S_PLAIN: begin
        if (st.out_free) begin
          cmd.out_plain = 1'b1;
          cmd.mix_start = 1'b1;
          cmd.mix_sel   = MIX_TAG_STEP;
          state_next    = S_TAG_STEP;
        end
      end
      S_TAG_STEP: begin
        if (st.mix_done) begin
          cmd.tag_wr = 1'b1;
          if (st.final_byte) begin
            state_next = S_FIN;
          end else begin
            cmd.pos_inc = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_FIN: begin
        code_next  = st.tag_ok ? ST_OK : ST_TAG;
        state_next = S_STAT;
      end
      S_STAT: begin
        if (st.out_free) begin
          cmd.out_status = 1'b1;
          cmd.close      = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_STAT))
    else $error("final tag check did not lead to status");

endmodule

// ===== rtl/kbsd_dp.sv =====
// ----------------------------------------------------------------------------
// kbsd_dp
// Datapath: header fields, keystream, tag, decode and result register.
// ----------------------------------------------------------------------------
module kbsd_dp (
  input  logic             clk,
  input  logic             rst,
  input  kbsd_pkg::cmd_t   cmd,
  output kbsd_pkg::stat_t  st,
  input  kbsd_pkg::src_t   src_data,
  input  logic             key_we,
  input  logic [63:0]      key_data,
  output logic             res_valid,
  input  logic             res_stall,
  output kbsd_pkg::res_t   res_data
);
  import kbsd_pkg::*;

  logic [PosW-1:0] pos;
  logic            err_seen;
  logic [63:0]     key_seed;
  logic [31:0]     msg_len;
  logic [63:0]     exp_tag;
  logic [63:0]     ks;
  logic [63:0]     tag;
  logic [7:0]      pend;
  logic [7:0]      b;
  logic            last;

  logic [PosW-1:0] final_pos;
  logic [PosW-1:0] idx1;
  logic [7:0]      magic;
  logic [7:0]      key;
  logic [15:0]     rot_dbl;
  logic [7:0]      plain;
  logic [63:0]     mix_arg;
  logic            mix_busy;
  logic            mix_done;
  logic [63:0]     mix_res;
  logic            in_hdr;
  logic            op_ok;
  logic [1:0]      len_lane;
  logic [2:0]      tag_lane;

  assign final_pos = PosW'(HdrBytes - 1) + {1'b0, msg_len, 1'b0};
  assign idx1      = (pos - PosW'(HdrBytes - 2)) >> 1;
  assign in_hdr    = (pos < PosW'(HdrBytes));
  assign key       = ks[7:0];
  assign rot_dbl   = {b, b} >> ks[10:8];
  assign op_ok     = (pend == OP_XOR) || (pend == OP_ROT) || (pend == OP_SUB);
  assign len_lane  = 2'(pos[4:0] - 5'd5);
  assign tag_lane  = 3'(pos[4:0] - 5'd9);

  always_comb begin
    case (pos[1:0])
      2'd0:    magic = 8'h4D;
      2'd1:    magic = 8'h49;
      2'd2:    magic = 8'h55;
      default: magic = 8'h56;
    endcase
  end

  always_comb begin
    case (pend)
      OP_XOR:  plain = b ^ key;
      OP_ROT:  plain = rot_dbl[7:0] ^ key;
      OP_SUB:  plain = b - key;
      default: plain = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.mix_sel)
      MIX_KS_INIT:  mix_arg = key_seed ^ MIX_GOLDEN ^ {32'b0, msg_len};
      MIX_TAG_INIT: mix_arg = key_seed ^ TAG_SALT ^ {32'b0, msg_len};
      MIX_KS_STEP:  mix_arg = ks + {{(64-PosW){1'b0}}, idx1};
      default:      mix_arg = tag ^ ({56'b0, plain} + TAG_BIAS);
    endcase
  end

  kbsd_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mix_start),
    .arg    (mix_arg),
    .busy   (mix_busy),
    .done   (mix_done),
    .result (mix_res)
  );

  // byte classification, in the order the checks take priority
  always_comb begin
    st            = '0;
    st.swallow    = err_seen;
    st.last       = last;
    st.len_zero   = (msg_len == 32'd0);
    st.final_byte = (pos == final_pos);
    st.tag_ok     = (tag == exp_tag);
    st.mix_done   = mix_done;
    st.out_free   = !res_valid || !res_stall;
    st.err_code   = ST_OK;
    if (in_hdr) begin
      if (last && pos < PosW'(HdrBytes - 1)) begin
        st.err      = 1'b1;
        st.err_code = ST_SHORT;
      end else if (pos < PosW'(4) && b != magic) begin
        st.err      = 1'b1;
        st.err_code = ST_MAGIC;
      end else if (pos == PosW'(4) && b != 8'd1) begin
        st.err      = 1'b1;
        st.err_code = ST_VERSION;
      end else if (pos < PosW'(HdrBytes - 1)) begin
        st.hdr_step = 1'b1;
      end else begin
        st.hdr_final = 1'b1;
      end
    end else if (last != st.final_byte) begin
      st.err      = 1'b1;
      st.err_code = ST_LENGTH;
    end else if (pos[0]) begin
      st.op_byte = 1'b1;
    end else if (!op_ok) begin
      st.err      = 1'b1;
      st.err_code = ST_BAD_OP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      err_seen  <= 1'b0;
      key_seed  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (key_we) key_seed <= key_data;
      if (cmd.pos_inc) pos <= pos + PosW'(1);
      if (cmd.close || cmd.swallow) begin
        if (last) begin
          pos      <= '0;
          err_seen <= 1'b0;
        end else begin
          err_seen <= 1'b1;
        end
      end
      if (cmd.out_plain || cmd.out_status) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      b    <= src_data.in_byte;
      last <= src_data.in_last;
    end
    if (cmd.hdr_store) begin
      if (pos >= PosW'(5) && pos < PosW'(9)) msg_len[len_lane*8 +: 8] <= b;
      if (pos >= PosW'(9)) exp_tag[tag_lane*8 +: 8] <= b;
    end
    if (cmd.pend_store) pend <= b;
    if (cmd.ks_wr) ks <= mix_res;
    if (cmd.tag_wr) tag <= mix_res;
    if (cmd.out_plain) begin
      res_data.kind           <= 1'b0;
      res_data.plain_byte     <= plain;
      res_data.status         <= ST_OK;
      res_data.end_of_message <= 1'b0;
    end else if (cmd.out_status) begin
      res_data.kind           <= 1'b1;
      res_data.plain_byte     <= 8'h00;
      res_data.status         <= cmd.code;
      res_data.end_of_message <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.mix_start |-> !mix_busy)
    else $error("mix started while busy");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.out_plain || cmd.out_status) |-> st.out_free)
    else $error("result loaded over an untaken result");
  assert property (@(posedge clk) disable iff (rst) !(cmd.out_plain && cmd.out_status))
    else $error("two results loaded at once");

endmodule

// ===== rtl/keyed_byte_stream_deobfuscator_core.sv =====
// ----------------------------------------------------------------------------
// keyed_byte_stream_deobfuscator_core
// Streaming deobfuscator: header parse, keyed byte decode, tag check.
// ----------------------------------------------------------------------------
// Header and op bytes are accepted, then classified, and the sequencer returns to idle.
// A cipher byte runs two SplitMix64 passes, keystream then tag, on the single
// shared 32x32 multiplier; the last header byte runs the two init passes too.
// Plaintext is loaded into the result register between the two passes, once it is free.
// rst (synchronous) clears position, error flag, seed and the result stage.
module keyed_byte_stream_deobfuscator_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  kbsd_pkg::src_t  src_data,
  output logic            res_valid,
  input  logic            res_stall,
  output kbsd_pkg::res_t  res_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [63:0]     cfg_data
);
  import kbsd_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // seed writes must come only while idle (the block does not enforce this); the port always takes the transfer
  assign cfg_ready = 1'b1;

  kbsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .st        (st),
    .cmd       (cmd)
  );

  kbsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .src_data  (src_data),
    .key_we    (cfg_valid && cfg_ready),
    .key_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
